/* sv/psg_pkg.sv */
// shared types, codes and constants of the tone/noise sound generator
// no dependencies; imported by every module of the block but psg_fifo
package psg_pkg;

   localparam int PERIOD_W = 10;
   localparam int CNT_W    = 14;
   localparam int ATT_W    = 4;
   localparam int LEVEL_W  = 11;
   localparam int SUM_W    = 13;
   localparam int NOISE_W  = 16;
   localparam int KIND_W   = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // input word operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // command kinds passed from the front end to the core
   localparam logic [KIND_W-1:0] CMD_TICK       = 3'd0;
   localparam logic [KIND_W-1:0] CMD_TONE_LOW   = 3'd1;
   localparam logic [KIND_W-1:0] CMD_ATTEN      = 3'd2;
   localparam logic [KIND_W-1:0] CMD_NOISE_CTRL = 3'd3;
   localparam logic [KIND_W-1:0] CMD_STEREO     = 3'd4;
   localparam logic [KIND_W-1:0] CMD_TONE_HIGH  = 3'd5;

   localparam logic [7:0] ADDR_NOISE_CTRL = 8'h06;
   localparam logic [7:0] ADDR_STEREO     = 8'h4F;

   localparam logic [1:0] NOISE_CHAN = 2'd3;
   localparam logic [NOISE_W-1:0] NOISE_INIT = 16'h8000;

   // csr register indexes
   localparam logic CSR_TONE_CUTOFF = 1'b0;
   localparam logic [PERIOD_W-1:0] CUTOFF_RESET = 10'd6;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [1:0]        chan;
      logic [7:0]        data;
   } psg_cmd_type;

   typedef struct packed {
      logic [SUM_W-1:0] left_level;
      logic [SUM_W-1:0] right_level;
   } psg_res_type;

   typedef struct packed {
      logic             fire;
      logic [CNT_W-1:0] count;
   } psg_cnt_type;

   // attenuation to output level
   function automatic logic [LEVEL_W-1:0] vol_level(input logic [ATT_W-1:0] att);
      logic [LEVEL_W-1:0] lvl;
      unique case (att)
         4'd0:  lvl = 11'd1516;
         4'd1:  lvl = 11'd1205;
         4'd2:  lvl = 11'd957;
         4'd3:  lvl = 11'd760;
         4'd4:  lvl = 11'd603;
         4'd5:  lvl = 11'd479;
         4'd6:  lvl = 11'd381;
         4'd7:  lvl = 11'd303;
         4'd8:  lvl = 11'd240;
         4'd9:  lvl = 11'd191;
         4'd10: lvl = 11'd152;
         4'd11: lvl = 11'd120;
         4'd12: lvl = 11'd96;
         4'd13: lvl = 11'd76;
         4'd14: lvl = 11'd60;
         4'd15: lvl = 11'd0;
      endcase
      return lvl;
   endfunction

   // one count of a channel down counter; period is already nonzero
   function automatic psg_cnt_type cnt_step(input logic [CNT_W-1:0] cnt,
                                            input logic [PERIOD_W-1:0] period);
      psg_cnt_type r;
      logic [CNT_W-1:0] reload;
      reload = {period, 4'b0000};
      r.fire = (cnt == CNT_W'(0)) || (cnt == CNT_W'(1));
      if (cnt == CNT_W'(0)) begin
         r.count = reload - CNT_W'(1);
      end else if (cnt == CNT_W'(1)) begin
         r.count = reload;
      end else begin
         r.count = cnt - CNT_W'(1);
      end
      return r;
   endfunction

endpackage

/* sv/psg_fifo.sv */
// small register queue with count based full/empty flags
// generic; used for the command queue and the result queue
module psg_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == CW'(0));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? AW'(0) : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? AW'(0) : rd_ptr_ff + AW'(1);
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* sv/psg_front.sv */
// front end: classifies input words into commands and queues them
// depends on psg_pkg and psg_fifo
module psg_front #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic                operation,
   input  logic [7:0]          reg_address,
   input  logic [7:0]          write_value,
   output logic                cmd_valid,
   input  logic                cmd_take,
   output psg_pkg::psg_cmd_type cmd
);
   import psg_pkg::*;

   psg_cmd_type dec;
   logic        cmd_empty;

   always_comb begin
      dec.chan = reg_address[2:1];
      dec.data = write_value;
      priority if (operation == OP_TICK) begin
         dec.kind = CMD_TICK;
      end else if (reg_address[7:3] == 5'd0 && !reg_address[0] &&
                   reg_address[2:1] != 2'd3) begin
         dec.kind = CMD_TONE_LOW;
      end else if (reg_address[7:3] == 5'd0 && reg_address[0]) begin
         dec.kind = CMD_ATTEN;
      end else if (reg_address == ADDR_NOISE_CTRL) begin
         dec.kind = CMD_NOISE_CTRL;
      end else if (reg_address == ADDR_STEREO) begin
         dec.kind = CMD_STEREO;
      end else begin
         dec.kind = CMD_TONE_HIGH;
      end
   end

   psg_fifo #(
      .WIDTH ($bits(psg_cmd_type)),
      .DEPTH (DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (dec),
      .full    (full),
      .pop     (cmd_take),
      .rd_data (cmd),
      .empty   (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;

endmodule

/* sv/psg_core.sv */
// back end: channel registers, down counters, noise lfsr and stereo mix
// depends on psg_pkg
module psg_core #(
   parameter int TONE_CHANNELS = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   output logic                            cmd_take,
   input  psg_pkg::psg_cmd_type            cmd,
   input  logic [psg_pkg::PERIOD_W-1:0]    tone_cutoff,
   input  logic                            res_full,
   output logic                            res_push,
   output psg_pkg::psg_res_type            res
);
   import psg_pkg::*;

   localparam logic [1:0] RATE_16   = 2'd0;
   localparam logic [1:0] RATE_32   = 2'd1;
   localparam logic [1:0] RATE_64   = 2'd2;
   localparam logic [1:0] RATE_TONE = 2'd3;

   logic exec_write, exec_tick;

   logic [PERIOD_W-1:0] period_ff [TONE_CHANNELS];
   logic [PERIOD_W-1:0] period_in [TONE_CHANNELS];
   logic [ATT_W-1:0]    att_ff    [TONE_CHANNELS];
   logic [ATT_W-1:0]    att_in    [TONE_CHANNELS];
   logic [CNT_W-1:0]    cnt_ff    [TONE_CHANNELS];
   logic [CNT_W-1:0]    cnt_in    [TONE_CHANNELS];
   logic                phase_ff  [TONE_CHANNELS];
   logic                phase_in  [TONE_CHANNELS];
   logic [LEVEL_W-1:0]  level_ff  [TONE_CHANNELS];
   logic [LEVEL_W-1:0]  level_in  [TONE_CHANNELS];

   logic [ATT_W-1:0]    natt_ff, natt_in;
   logic [CNT_W-1:0]    ncnt_ff, ncnt_in;
   logic                nphase_ff, nphase_in;
   logic [LEVEL_W-1:0]  nlevel_ff, nlevel_in;
   logic [NOISE_W-1:0]  shift_ff, shift_in;
   logic [1:0]          rate_ff, rate_in;
   logic                periodic_ff, periodic_in;
   logic [1:0]          latched_ff, latched_in;
   logic [7:0]          stereo_ff, stereo_in;
   logic [PERIOD_W-1:0] ntp_ff, ntp_in;
   logic [PERIOD_W-1:0] nperiod;
   psg_cnt_type         nstep;
   logic                fb;

   // a tick needs room in the result queue, writes never stall
   assign cmd_take   = cmd_valid && (cmd.kind != CMD_TICK || !res_full);
   assign exec_write = cmd_take && cmd.kind != CMD_TICK;
   assign exec_tick  = cmd_take && cmd.kind == CMD_TICK;

   for (genvar g = 0; g < TONE_CHANNELS; g++) begin : g_tone
      logic [PERIOD_W-1:0] eff;
      psg_cnt_type         step;

      always_comb begin
         period_in[g] = period_ff[g];
         att_in[g]    = att_ff[g];
         cnt_in[g]    = cnt_ff[g];
         phase_in[g]  = phase_ff[g];
         level_in[g]  = level_ff[g];
         eff  = (period_ff[g] == '0) ? PERIOD_W'(1) : period_ff[g];
         step = cnt_step(cnt_ff[g], eff);
         if (exec_write && cmd.kind == CMD_TONE_LOW && cmd.chan == 2'(g)) begin
            period_in[g] = {period_ff[g][PERIOD_W-1:4], cmd.data[3:0]};
         end
         if (exec_write && cmd.kind == CMD_TONE_HIGH && latched_ff == 2'(g)) begin
            period_in[g] = {cmd.data[5:0], period_ff[g][3:0]};
         end
         if (exec_write && cmd.kind == CMD_ATTEN && cmd.chan == 2'(g)) begin
            att_in[g] = cmd.data[ATT_W-1:0];
         end
         if (exec_tick) begin
            cnt_in[g] = step.count;
            if (step.fire) begin
               // short periods are muted
               phase_in[g] = (eff > tone_cutoff) ? !phase_ff[g] : 1'b0;
               level_in[g] = phase_in[g] ? vol_level(att_ff[g]) : '0;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            period_ff[g] <= '0;
            att_ff[g]    <= '1;
            cnt_ff[g]    <= '0;
            phase_ff[g]  <= 1'b1;
            level_ff[g]  <= '0;
         end else begin
            period_ff[g] <= period_in[g];
            att_ff[g]    <= att_in[g];
            cnt_ff[g]    <= cnt_in[g];
            phase_ff[g]  <= phase_in[g];
            level_ff[g]  <= level_in[g];
         end
      end
   end

   // noise rate 3 follows tone channel 2
   if (TONE_CHANNELS >= 3) begin : g_ntp
      always_comb begin
         ntp_in = ntp_ff;
         if (exec_write &&
             ((cmd.kind == CMD_TONE_LOW && cmd.chan == 2'd2) ||
              (cmd.kind == CMD_ATTEN && cmd.chan == 2'd2) ||
              (cmd.kind == CMD_TONE_HIGH && latched_ff == 2'd2))) begin
            ntp_in = period_in[2];
         end
      end
   end else begin : g_no_ntp
      assign ntp_in = ntp_ff;
   end

   always_comb begin
      unique case (rate_ff)
         RATE_16:   nperiod = PERIOD_W'(16);
         RATE_32:   nperiod = PERIOD_W'(32);
         RATE_64:   nperiod = PERIOD_W'(64);
         RATE_TONE: nperiod = (ntp_ff == '0) ? PERIOD_W'(1) : ntp_ff;
      endcase
   end

   always_comb begin
      natt_in     = natt_ff;
      ncnt_in     = ncnt_ff;
      nphase_in   = nphase_ff;
      nlevel_in   = nlevel_ff;
      shift_in    = shift_ff;
      rate_in     = rate_ff;
      periodic_in = periodic_ff;
      latched_in  = latched_ff;
      stereo_in   = stereo_ff;
      nstep       = cnt_step(ncnt_ff, nperiod);
      fb          = periodic_ff ? shift_ff[0] : (shift_ff[0] ^ shift_ff[3]);
      if (exec_write) begin
         unique case (cmd.kind)
            CMD_TONE_LOW: latched_in = cmd.chan;
            CMD_ATTEN: begin
               if (cmd.chan == NOISE_CHAN) begin
                  natt_in = cmd.data[ATT_W-1:0];
               end
            end
            CMD_NOISE_CTRL: begin
               rate_in     = cmd.data[1:0];
               periodic_in = !cmd.data[2];
               shift_in    = NOISE_INIT;
            end
            CMD_STEREO: stereo_in = cmd.data;
            default: ;
         endcase
      end
      if (exec_tick) begin
         ncnt_in = nstep.count;
         if (nstep.fire) begin
            nphase_in = !nphase_ff;
            // lfsr advances on the rising half only
            if (nphase_in) begin
               shift_in  = {fb, shift_ff[NOISE_W-1:1]};
               nlevel_in = shift_in[0] ? vol_level(natt_ff) : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         natt_ff     <= '1;
         ncnt_ff     <= '0;
         nphase_ff   <= 1'b1;
         nlevel_ff   <= '0;
         shift_ff    <= NOISE_INIT;
         rate_ff     <= RATE_16;
         periodic_ff <= 1'b0;
         latched_ff  <= '0;
         stereo_ff   <= '1;
         ntp_ff      <= '0;
      end else begin
         natt_ff     <= natt_in;
         ncnt_ff     <= ncnt_in;
         nphase_ff   <= nphase_in;
         nlevel_ff   <= nlevel_in;
         shift_ff    <= shift_in;
         rate_ff     <= rate_in;
         periodic_ff <= periodic_in;
         latched_ff  <= latched_in;
         stereo_ff   <= stereo_in;
         ntp_ff      <= ntp_in;
      end
   end

   // stereo mix of the levels after this tick
   always_comb begin
      res.left_level  = stereo_ff[7] ? SUM_W'(nlevel_in) : '0;
      res.right_level = stereo_ff[3] ? SUM_W'(nlevel_in) : '0;
      for (int i = 0; i < TONE_CHANNELS; i++) begin
         if (stereo_ff[4 + i]) begin
            res.left_level = res.left_level + SUM_W'(level_in[i]);
         end
         if (stereo_ff[i]) begin
            res.right_level = res.right_level + SUM_W'(level_in[i]);
         end
      end
   end

   assign res_push = exec_tick;

endmodule

/* sv/psg_tone_noise_generator_unit.sv */
// top level of the three tone, one noise sound generator
// depends on psg_pkg, psg_fifo, psg_front and psg_core
//
// usage
//  - input queue: a word is taken when push is high and full is low. a word
//    is either a register write (req_operation 0, req_reg_address and
//    req_write_value) or one time tick (req_operation 1)
//  - result queue: one word per tick (rsp_left_level, rsp_right_level) is
//    presented while empty is low and leaves when pop is high; writes give
//    no result word
//  - csr port: register 0 (byte address 0) is the tone cutoff, 10 bits,
//    reset 6; written in the apb access phase, pready is tied high
//  - path: a tick word goes through the command queue, then the result
//    queue; one word per cycle sustained, back to back, while results are
//    popped; the core sets throughput, retiring one command per cycle unless a tick
//    meets a full result queue; all four channel counters update in parallel
//  - a receiver stall first fills the result queue, then parks ticks in the
//    command queue and finally raises full; writes ahead of a parked tick
//    still drain
//  - reset clears both queues and puts every channel in its silent state
module psg_tone_noise_generator_unit #(
   parameter int TONE_CHANNELS = 3,
   parameter int CMD_DEPTH     = 2,
   parameter int RSP_DEPTH     = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   // input queue
   input  logic                              push,
   output logic                              full,
   input  logic                              req_operation,
   input  logic [7:0]                        req_reg_address,
   input  logic [7:0]                        req_write_value,
   // result queue
   output logic                              empty,
   input  logic                              pop,
   output logic [psg_pkg::SUM_W-1:0]         rsp_left_level,
   output logic [psg_pkg::SUM_W-1:0]         rsp_right_level,
   // csr port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [psg_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [psg_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [psg_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import psg_pkg::*;

   logic                cmd_valid, cmd_take;
   psg_cmd_type         cmd;
   logic                res_full, res_push;
   psg_res_type         res, rsp_word;
   logic [PERIOD_W-1:0] cutoff_ff, cutoff_in;
   logic                csr_write;

   // csr: word index is paddr[2], only index 0 exists
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cutoff_in = cutoff_ff;
      if (csr_write && paddr[2] == CSR_TONE_CUTOFF) begin
         cutoff_in = pwdata[PERIOD_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_TONE_CUTOFF) begin
         prdata = CSR_DATA_W'(cutoff_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= CUTOFF_RESET;
      end else begin
         cutoff_ff <= cutoff_in;
      end
   end

   // front end: decode and command queue
   psg_front #(
      .DEPTH (CMD_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .operation   (req_operation),
      .reg_address (req_reg_address),
      .write_value (req_write_value),
      .cmd_valid   (cmd_valid),
      .cmd_take    (cmd_take),
      .cmd         (cmd)
   );

   // back end: channel state and mixing
   psg_core #(
      .TONE_CHANNELS (TONE_CHANNELS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_take    (cmd_take),
      .cmd         (cmd),
      .tone_cutoff (cutoff_ff),
      .res_full    (res_full),
      .res_push    (res_push),
      .res         (res)
   );

   // result queue decouples the core from the receiver
   psg_fifo #(
      .WIDTH ($bits(psg_res_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_push),
      .wr_data (res),
      .full    (res_full),
      .pop     (pop),
      .rd_data (rsp_word),
      .empty   (empty)
   );

   assign rsp_left_level  = rsp_word.left_level;
   assign rsp_right_level = rsp_word.right_level;

endmodule
